@@ rtl/cbpw_pkg.sv @@
package cbpw_pkg;

  localparam int COORD_BITS       = 12;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int SIZE_W  = 13;
  localparam int SHIFT_W = 16;
  localparam int DIST_W  = 24;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 24;
  localparam int OUT_W   = WEIGHT_FRAC_BITS + 1;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_HSHIFT = 3'd2;
  localparam logic [IDX_W-1:0] REG_VSHIFT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIST   = 3'd4;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1024;
  localparam logic [DIST_W-1:0] DIST_RST   = 24'd1048576;

  // signed pixel offset in Q8
  localparam int DX_W  = ((COORD_BITS + 8 > SIZE_W + 7) ? COORD_BITS + 8 : SIZE_W + 7) + 2;
  localparam int MAG_W = DX_W - 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int D2_W  = 2 * DIST_W;
  localparam int S_W   = ((SQ_W + 1 > D2_W) ? SQ_W + 1 : D2_W) + 2;
  localparam int E_W   = S_W + 2 * WEIGHT_FRAC_BITS + 4;
  localparam int NST   = WEIGHT_FRAC_BITS + 1;

endpackage

@@ rtl/cone_beam_pixel_weight_unit.sv @@
// Cone-beam cosine weight per detector pixel: D / sqrt(dx^2 + dy^2 + D^2),
// unsigned Q1.16, rounded to nearest and capped at 1.0.
// Input channel: in_valid/in_ready with in_pixel_column and in_pixel_row.
// Result channel: out_valid/out_ready with out_weight_q16, one per pixel,
// in input order.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects
// 0 width, 1 height, 2 horizontal shift, 3 vertical shift, 4 distance;
// other indexes are ignored. Write only while no pixel is in flight.
// Pipeline from an input transfer to the result: the transfer edge loads the
// offset register, then squaring, sum, seventeen restoring steps (one weight
// bit each, shift-add only) and the output register.
// Throughput: one pixel per cycle unless the receiver stalls; every step holds one pixel.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults: 1024 x 1024, zero shifts, distance 4096.0.
module cone_beam_pixel_weight_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cbpw_pkg::COORD_BITS-1:0]      in_pixel_column,
  input  logic [cbpw_pkg::COORD_BITS-1:0]      in_pixel_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cbpw_pkg::OUT_W-1:0]           out_weight_q16,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cbpw_pkg::IDX_W-1:0]           cfg_index,
  input  logic [cbpw_pkg::DATA_W-1:0]          cfg_data
);

  localparam int WFB = cbpw_pkg::WEIGHT_FRAC_BITS;
  localparam int NST = cbpw_pkg::NST;
  localparam int DXW = cbpw_pkg::DX_W;
  localparam int MW  = cbpw_pkg::MAG_W;
  localparam int SQW = cbpw_pkg::SQ_W;
  localparam int D2W = cbpw_pkg::D2_W;
  localparam int SW  = cbpw_pkg::S_W;
  localparam int EW  = cbpw_pkg::E_W;
  localparam int ZW  = cbpw_pkg::SIZE_W;
  localparam int HW  = cbpw_pkg::SHIFT_W;
  localparam int DW  = cbpw_pkg::DIST_W;

  logic [ZW-1:0]        width_r, height_r;
  logic signed [HW-1:0] hshift_r, vshift_r;
  logic [DW-1:0]        dist_r;

  logic en;

  logic                 v1_r, v2_r;
  logic [MW-1:0]        mx_r, my_r;
  logic [SQW-1:0]       sqx_r, sqy_r;
  logic [D2W-1:0]       d2_r;

  logic signed [DXW-1:0] dx, dy, t_col, t_row, t_w, t_h, t_hs, t_vs;
  logic [MW-1:0]         mx, my;
  logic [SW-1:0]         s_sum;

  logic                 v_r    [NST+1];
  logic                 zero_r [NST+1];
  logic                 done_r [NST+1];
  logic [WFB:0]         w_r    [NST+1];
  logic [SW-1:0]        s_r    [NST+1];
  logic signed [EW-1:0] e_r    [NST+1];
  logic signed [EW-1:0] qs_r   [NST+1];

  logic                 done_nxt [NST];
  logic [WFB:0]         w_nxt    [NST];
  logic signed [EW-1:0] e_nxt    [NST];
  logic signed [EW-1:0] qs_nxt   [NST];

  logic                    out_valid_r;
  logic [cbpw_pkg::OUT_W-1:0] out_weight_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_weight_q16 = out_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cbpw_pkg::WIDTH_RST;
      height_r <= cbpw_pkg::HEIGHT_RST;
      hshift_r <= '0;
      vshift_r <= '0;
      dist_r   <= cbpw_pkg::DIST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbpw_pkg::REG_WIDTH:  width_r  <= cfg_data[ZW-1:0];
        cbpw_pkg::REG_HEIGHT: height_r <= cfg_data[ZW-1:0];
        cbpw_pkg::REG_HSHIFT: hshift_r <= cfg_data[HW-1:0];
        cbpw_pkg::REG_VSHIFT: vshift_r <= cfg_data[HW-1:0];
        cbpw_pkg::REG_DIST:   dist_r   <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t_col = signed'(DXW'({in_pixel_column, 8'd128}));
    t_row = signed'(DXW'({in_pixel_row, 8'd128}));
    t_w   = signed'(DXW'({width_r, 7'd0}));
    t_h   = signed'(DXW'({height_r, 7'd0}));
    t_hs  = DXW'(hshift_r);
    t_vs  = DXW'(vshift_r);
    dx    = t_col - t_w - t_hs;
    dy    = t_row - t_h - t_vs;
    mx    = dx[DXW-1] ? MW'(-dx) : MW'(dx);
    my    = dy[DXW-1] ? MW'(-dy) : MW'(dy);
    s_sum = SW'(sqx_r) + SW'(sqy_r) + SW'(d2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int j = 0; j <= NST; j++) begin
        v_r[j] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v_r[0] <= v2_r;
      for (int j = 0; j < NST; j++) begin
        v_r[j+1] <= v_r[j];
      end
      out_valid_r <= v_r[NST];
    end
  end

  always_comb begin
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] t;
    logic                 ok;
    for (int j = 0; j < NST; j++) begin
      sx = signed'(EW'(s_r[j]));
      t  = e_r[j] - (qs_r[j] <<< (WFB - j + 2)) - (sx <<< (2 * (WFB - j) + 2));
      ok = !t[EW-1] && !done_r[j];
      e_nxt[j]    = ok ? t : e_r[j];
      qs_nxt[j]   = ok ? qs_r[j] + (sx <<< (WFB - j + 1)) : qs_r[j];
      w_nxt[j]    = ok ? (w_r[j] | ((WFB + 1)'(1) << (WFB - j))) : w_r[j];
      done_nxt[j] = done_r[j] || (ok && (j == 0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= mx;
      my_r  <= my;
      sqx_r <= mx_r * mx_r;
      sqy_r <= my_r * my_r;
      d2_r  <= dist_r * dist_r;
      s_r[0]    <= s_sum;
      e_r[0]    <= (signed'(EW'(d2_r)) <<< (2 * WFB + 2)) - signed'(EW'(s_sum));
      qs_r[0]   <= -signed'(EW'(s_sum));
      w_r[0]    <= '0;
      done_r[0] <= 1'b0;
      zero_r[0] <= (dist_r == '0);
      for (int j = 0; j < NST; j++) begin
        s_r[j+1]    <= s_r[j];
        e_r[j+1]    <= e_nxt[j];
        qs_r[j+1]   <= qs_nxt[j];
        w_r[j+1]    <= w_nxt[j];
        done_r[j+1] <= done_nxt[j];
        zero_r[j+1] <= zero_r[j];
      end
      out_weight_r <= zero_r[NST] ? '0 : w_r[NST];
    end
  end

  a_out_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_weight_r <= (cbpw_pkg::OUT_W)'(1) << WFB)
    else $error("weight above 1.0");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST] && done_r[NST] |-> w_r[NST] == ((WFB + 1)'(1) << WFB))
    else $error("full-scale weight carries low bits");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r[NST]) && $stable(w_r[NST]) && $stable(v1_r))
    else $error("pipeline moved during stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r && !v_r[NST])
    else $error("pipeline not empty after reset");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W            = cbpw_pkg::IDX_W;
  localparam int DATA_W           = cbpw_pkg::DATA_W;
  localparam int COORD_BITS       = cbpw_pkg::COORD_BITS;
  localparam int OUT_W            = cbpw_pkg::OUT_W;
  localparam int SIZE_W           = cbpw_pkg::SIZE_W;
  localparam int SHIFT_W          = cbpw_pkg::SHIFT_W;
  localparam int DIST_W           = cbpw_pkg::DIST_W;
  localparam int WEIGHT_FRAC_BITS = cbpw_pkg::WEIGHT_FRAC_BITS;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int PIPE_DEPTH    = 25;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_PIXELS  = 50;
  localparam int TYPED_NONE    = -1;

  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    int                col;
    int                row;
    int                weight;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] in_pixel_column = '0;
  logic [COORD_BITS-1:0] in_pixel_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] out_weight_q16;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  logic [SIZE_W-1:0]  width_sh  = cbpw_pkg::WIDTH_RST;
  logic [SIZE_W-1:0]  height_sh = cbpw_pkg::HEIGHT_RST;
  logic [SHIFT_W-1:0] hshift_sh = '0;
  logic [SHIFT_W-1:0] vshift_sh = '0;
  logic [DIST_W-1:0]  dist_sh   = cbpw_pkg::DIST_RST;

  int weight_q[$];
  int typed_q[$];
  int errors = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  stim_row_t directed[$] = '{
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       4095, 4095, TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       511,  511,  65536},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       512,  511,  65536},
    '{1, cbpw_pkg::REG_WIDTH,  24'd4096,    0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_HEIGHT, 24'd1,       0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       2047, 0,    65536},
    '{1, cbpw_pkg::REG_HSHIFT, 24'h008000,  0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_VSHIFT, 24'h007fff,  0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       0,    4095, TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       4095, 0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_DIST,   24'd256,     0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       2047, 0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_DIST,   24'hffffff,  0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       4095, 4095, TYPED_NONE},
    '{1, cbpw_pkg::REG_DIST,   24'd0,       0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       1,    2,    0},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       4095, 4095, 0},
    '{1, cbpw_pkg::REG_WIDTH,  24'd0,       0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_HEIGHT, 24'd8191,    0,    0,    TYPED_NONE},
    '{1, REG_UNUSED,           24'hffffff,  0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_DIST,   24'd1048576, 0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       123,  4000, TYPED_NONE},
    '{1, cbpw_pkg::REG_WIDTH,  24'd8191,    0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_HSHIFT, 24'd0,       0,    0,    TYPED_NONE},
    '{1, cbpw_pkg::REG_VSHIFT, 24'd0,       0,    0,    TYPED_NONE},
    '{0, cbpw_pkg::REG_WIDTH,  24'd0,       4095, 0,    TYPED_NONE}
  };

  cone_beam_pixel_weight_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_column(in_pixel_column),
    .in_pixel_row   (in_pixel_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_weight_q16 (out_weight_q16),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint offset_square(longint idx, longint size, logic [SHIFT_W-1:0] sh);
    longint d;
    d = (idx <<< 8) + 128 - (size <<< 7) - longint'(signed'(sh));
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic int cosine_weight(int col, int row);
    logic [127:0] dist_sq;
    logic [127:0] sum_sq;
    logic [127:0] bound;
    logic [127:0] t;
    longint lo_w;
    longint hi_w;
    longint mid;
    if (dist_sh == 0) return 0;
    dist_sq = 128'(dist_sh) * 128'(dist_sh);
    sum_sq = 128'(offset_square(col, width_sh, hshift_sh))
           + 128'(offset_square(row, height_sh, vshift_sh)) + dist_sq;
    bound = dist_sq << (2 + 2 * WEIGHT_FRAC_BITS);
    lo_w = 0;
    hi_w = longint'(1) << WEIGHT_FRAC_BITS;
    while (lo_w < hi_w) begin
      mid = lo_w + ((hi_w - lo_w + 1) >>> 1);
      t = 128'(2 * mid - 1);
      if (t * t * sum_sq <= bound) lo_w = mid;
      else hi_w = mid - 1;
    end
    return int'(lo_w);
  endfunction

  always @(posedge clk) begin
    int typed;
    int want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("cone_beam_pixel_weight_unit regression: fail");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (weight_q.size() == 0) begin
          $error("weight_q16: unexpected result %0d", out_weight_q16);
          errors++;
        end else begin
          want = weight_q.pop_front();
          if (out_weight_q16 !== OUT_W'(want)) begin
            $error("weight_q16: expected %0d, actual %0d", want, out_weight_q16);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        typed = typed_q.pop_front();
        weight_q.push_back(typed >= 0 ? typed : cosine_weight(in_pixel_column, in_pixel_row));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbpw_pkg::REG_WIDTH:  width_sh  <= cfg_data[SIZE_W-1:0];
          cbpw_pkg::REG_HEIGHT: height_sh <= cfg_data[SIZE_W-1:0];
          cbpw_pkg::REG_HSHIFT: hshift_sh <= cfg_data[SHIFT_W-1:0];
          cbpw_pkg::REG_VSHIFT: vshift_sh <= cfg_data[SHIFT_W-1:0];
          cbpw_pkg::REG_DIST:   dist_sh   <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic send_pixel(int col, int row, int typed);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk);
    end
    typed_q.push_back(typed);
    in_pixel_column = COORD_BITS'(col);
    in_pixel_row = COORD_BITS'(row);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid = 1'b0;
    while (weight_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return DATA_W'($urandom);
      1: return DATA_W'($urandom_range(1, 16));
      default: return DATA_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_shift();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom);
      default: return DATA_W'(SHIFT_W'($urandom_range(0, 2048) - 1024));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_dist();
    case ($urandom_range(0, 7))
      0: return DATA_W'($urandom);
      1: return DATA_W'($urandom_range(256, 4096));
      default: return DATA_W'($urandom_range(65536, 2097152));
    endcase
  endfunction

  initial begin
    stim_row_t r;
    int w;
    int h;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      r = directed[i];
      if (r.is_cfg) begin
        drain_pipe();
        write_reg(r.idx, r.data);
      end else begin
        send_pixel(r.col, r.row, r.weight);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_pipe();
      write_reg(cbpw_pkg::REG_WIDTH, pick_size());
      write_reg(cbpw_pkg::REG_HEIGHT, pick_size());
      write_reg(cbpw_pkg::REG_HSHIFT, pick_shift());
      write_reg(cbpw_pkg::REG_VSHIFT, pick_shift());
      write_reg(cbpw_pkg::REG_DIST, pick_dist());
      if ($urandom_range(0, 3) == 0) write_reg(IDX_W'($urandom_range(5, 7)), DATA_W'($urandom));
      if (p == 1) hold_req = 1'b1;
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      w = (width_sh == 0) ? 1 : width_sh;
      h = (height_sh == 0) ? 1 : height_sh;
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), TYPED_NONE);
        else
          send_pixel($urandom_range(0, (w > 4096 ? 4096 : w) - 1),
                     $urandom_range(0, (h > 4096 ? 4096 : h) - 1), TYPED_NONE);
      end
    end

    drain_pipe();
    if (errors == 0) begin
      $display("cone_beam_pixel_weight_unit regression: pass");
    end else begin
      $display("cone_beam_pixel_weight_unit regression: fail");
    end
    $finish;
  end

endmodule
